### rtl/cp932_to_utf8_stream_decoder_top_assert.svh
// Assertion macros for the CP932 to UTF-8 decoder.
`ifndef CP932_TO_UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define CP932_TO_UTF8_STREAM_DECODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Property holds on every rising clock edge outside reset.
`define C2U_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition never true outside reset.
`define C2U_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define C2U_ASSERT(lbl, clk, rst_n, prop, msg)
`define C2U_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### rtl/c2u_pkg.sv
`default_nettype none

package c2u_pkg;

    localparam int LEAD_ROWS     = 60;
    localparam int TRAIL_COLUMNS = 188;
    localparam int TABLE_DEPTH   = LEAD_ROWS * TRAIL_COLUMNS;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CODE_W        = 16;
    localparam int ROW_W         = $clog2(LEAD_ROWS);

    // input actions (tuser)
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_BYTE   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    // result kinds (tuser)
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CODE,
        OP_TRAIL,
        OP_BAD,
        OP_FINISH
    } op_t;

    // item held between table read and emit
    typedef struct packed {
        op_t                 op;
        logic [CODE_W-1:0]   code;
        logic                lead;
    } stage_t;

    // group of up to three results handed to the output stage
    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] bytes;
        logic [15:0] length;
        logic [1:0]  count;
    } group_t;

endpackage

`default_nettype wire

### rtl/c2u_table_ram.sv
`default_nettype none

module c2u_table_ram (
    input  wire logic                        aclk,
    input  wire logic                        we,
    input  wire logic [c2u_pkg::ADDR_W-1:0]  waddr,
    input  wire logic [c2u_pkg::CODE_W-1:0]  wdata,
    input  wire logic                        re,
    input  wire logic [c2u_pkg::ADDR_W-1:0]  raddr,
    output logic      [c2u_pkg::CODE_W-1:0]  rdata
);

    logic [c2u_pkg::CODE_W-1:0] mem [0:c2u_pkg::TABLE_DEPTH-1];
    logic [c2u_pkg::CODE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/c2u_front.sv
`default_nettype none

module c2u_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [1:0]                  action,
    input  wire logic [7:0]                  in_byte,
    input  wire logic [13:0]                 entry_index,
    input  wire logic [15:0]                 entry_code,
    input  wire logic                        advance,
    output logic                             mem_we,
    output logic [c2u_pkg::ADDR_W-1:0]       mem_waddr,
    output logic [c2u_pkg::CODE_W-1:0]       mem_wdata,
    output logic                             mem_re,
    output logic [c2u_pkg::ADDR_W-1:0]       mem_raddr,
    output logic                             st_valid,
    output c2u_pkg::stage_t                  st
);

    logic                      lead_reg, lead_next;
    logic [c2u_pkg::ROW_W-1:0] row_reg, row_next;
    logic                      st_valid_reg, st_valid_next;
    c2u_pkg::stage_t           st_reg, st_next;
    c2u_pkg::stage_t           fresh;
    logic                      accept;
    logic [7:0]                col;
    logic                      col_ok;

    assign s_tready = !st_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        col_ok = 1'b1;
        col    = 8'd0;
        if (in_byte >= 8'h40 && in_byte <= 8'h7E) begin
            col = in_byte - 8'h40;
        end else if (in_byte >= 8'h80 && in_byte <= 8'hFC) begin
            col = in_byte - 8'h41;
        end else begin
            col_ok = 1'b0;
        end
    end

    assign mem_raddr = c2u_pkg::ADDR_W'({8'd0, row_reg}
                       * 14'(c2u_pkg::TRAIL_COLUMNS)) + c2u_pkg::ADDR_W'(col);
    assign mem_waddr = entry_index;
    assign mem_wdata = entry_code;
    assign mem_we    = accept && action == c2u_pkg::ACT_LOAD
                       && entry_index < 14'(c2u_pkg::TABLE_DEPTH);

    // lead tracking ignores the error flag: after an error nothing counts
    // until finish, which clears both
    always_comb begin
        fresh     = '{op: c2u_pkg::OP_NONE, code: '0, lead: lead_reg};
        lead_next = lead_reg;
        row_next  = row_reg;
        unique case (action)
            c2u_pkg::ACT_BYTE: begin
                if (lead_reg) begin
                    lead_next = 1'b0;
                    fresh.op  = col_ok ? c2u_pkg::OP_TRAIL : c2u_pkg::OP_BAD;
                end else if (in_byte <= 8'h80) begin
                    fresh.op   = c2u_pkg::OP_CODE;
                    fresh.code = {8'd0, in_byte};
                end else if (in_byte >= 8'hA1 && in_byte <= 8'hDF) begin
                    fresh.op   = c2u_pkg::OP_CODE;
                    fresh.code = 16'hFF61 + {8'd0, in_byte - 8'hA1};
                end else if (in_byte == 8'hA0) begin
                    fresh.op   = c2u_pkg::OP_CODE;
                    fresh.code = 16'hF8F0;
                end else if (in_byte >= 8'hFD) begin
                    fresh.op   = c2u_pkg::OP_CODE;
                    fresh.code = 16'hF8F1 + {8'd0, in_byte - 8'hFD};
                end else begin
                    lead_next = 1'b1;
                    row_next  = (in_byte <= 8'h9F) ? c2u_pkg::ROW_W'(in_byte - 8'h81)
                              : c2u_pkg::ROW_W'(in_byte - 8'hE0) + c2u_pkg::ROW_W'(31);
                end
            end
            c2u_pkg::ACT_FINISH: begin
                fresh.op  = c2u_pkg::OP_FINISH;
                lead_next = 1'b0;
                row_next  = '0;
            end
            default: begin
            end
        endcase
        if (!accept) begin
            lead_next = lead_reg;
            row_next  = row_reg;
        end
    end

    assign mem_re = accept && fresh.op == c2u_pkg::OP_TRAIL;

    always_comb begin
        st_valid_next = st_valid_reg;
        st_next       = st_reg;
        if (!st_valid_reg || advance) begin
            st_valid_next = accept;
            st_next       = fresh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg     <= 1'b0;
            row_reg      <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            lead_reg     <= lead_next;
            row_reg      <= row_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
    end

    assign st_valid = st_valid_reg;
    assign st       = st_reg;

endmodule

`default_nettype wire

### rtl/c2u_emit.sv
`default_nettype none

`include "cp932_to_utf8_stream_decoder_top_assert.svh"

module c2u_emit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [15:0]                 cfg_wr_data,
    input  wire logic                        st_valid,
    input  wire c2u_pkg::stage_t             st,
    input  wire logic [c2u_pkg::CODE_W-1:0]  rdata,
    input  wire logic                        can_take,
    output logic                             advance,
    output logic                             grp_load,
    output c2u_pkg::group_t                  grp
);

    logic [15:0]                cap_reg;
    logic                       err_reg, err_next;
    logic [15:0]                used_reg, used_next;
    logic [c2u_pkg::CODE_W-1:0] code;
    logic [1:0]                 cnt;
    logic                       room;
    logic [1:0]                 n;
    logic [23:0]                enc;

    assign code = (st.op == c2u_pkg::OP_TRAIL) ? rdata : st.code;
    assign cnt  = (code < 16'h0080) ? 2'd1 : (code < 16'h0800) ? 2'd2 : 2'd3;
    // terminator must still fit after the new bytes
    assign room = ({1'b0, used_reg} + {15'd0, cnt}) < {1'b0, cap_reg};

    always_comb begin
        case (cnt)
            2'd1:    enc = {16'd0, code[7:0]};
            2'd2:    enc = {8'd0, 2'b10, code[5:0], 3'b110, code[10:6]};
            default: enc = {2'b10, code[5:0], 2'b10, code[11:6], 4'b1110, code[15:12]};
        endcase
    end

    always_comb begin
        n         = 2'd0;
        err_next  = err_reg;
        used_next = used_reg;
        grp       = '{kind: c2u_pkg::KIND_DATA, bytes: enc, length: '0, count: cnt};
        case (st.op) inside
            c2u_pkg::OP_CODE, c2u_pkg::OP_TRAIL: begin
                if (!err_reg) begin
                    // a zero table entry is unmapped; a single byte of zero is NUL
                    if ((st.op == c2u_pkg::OP_TRAIL && code == '0) || !room) begin
                        err_next = 1'b1;
                    end else begin
                        n         = cnt;
                        used_next = used_reg + {14'd0, cnt};
                    end
                end
            end
            c2u_pkg::OP_BAD: begin
                err_next = 1'b1;
            end
            c2u_pkg::OP_FINISH: begin
                n         = 2'd1;
                grp.count = 2'd1;
                grp.bytes = '0;
                if (err_reg || st.lead || used_reg >= cap_reg) begin
                    grp.kind = c2u_pkg::KIND_ERR;
                end else begin
                    grp.kind   = c2u_pkg::KIND_OK;
                    grp.length = used_reg;
                end
                err_next  = 1'b0;
                used_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign advance  = st_valid && (n == 2'd0 || can_take);
    assign grp_load = advance && n != 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= 16'hFFFF;
            err_reg  <= 1'b0;
            used_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (advance) begin
                err_reg  <= err_next;
                used_reg <= used_next;
            end
        end
    end

    // count stays below the largest capacity, terminator included
    `C2U_NEVER(a_used_max, aclk, aresetn, used_reg == 16'hFFFF, "byte count overran")
    `C2U_ASSERT(a_err_silent, aclk, aresetn, advance && err_reg && st.op != c2u_pkg::OP_FINISH |-> !grp_load, "data emitted after error")

endmodule

`default_nettype wire

### rtl/c2u_out_ser.sv
`default_nettype none

`include "cp932_to_utf8_stream_decoder_top_assert.svh"

module c2u_out_ser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             grp_load,
    input  wire c2u_pkg::group_t  grp,
    output logic                  can_take,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic                  m_tlast,
    output logic [1:0]            m_tuser,
    output logic [23:0]           m_tdata
);

    logic [1:0]  left_reg, left_next;
    logic [23:0] bytes_reg, bytes_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] len_reg, len_next;

    assign m_tvalid = left_reg != 2'd0;
    assign m_tlast  = left_reg == 2'd1;
    assign can_take = left_reg == 2'd0 || (left_reg == 2'd1 && m_tready);

    always_comb begin
        left_next  = left_reg;
        bytes_next = bytes_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        if (grp_load) begin
            left_next  = grp.count;
            bytes_next = grp.bytes;
            kind_next  = grp.kind;
            len_next   = grp.length;
        end else if (m_tvalid && m_tready) begin
            left_next  = left_reg - 2'd1;
            bytes_next = {8'd0, bytes_reg[23:8]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        kind_reg  <= kind_next;
        len_reg   <= len_next;
    end

    assign m_tuser = kind_reg;
    assign m_tdata = {len_reg, bytes_reg[7:0]};

    `C2U_ASSERT(a_load_free, aclk, aresetn, grp_load |-> (left_reg == 2'd0 || (left_reg == 2'd1 && m_tready)), "group loaded over pending bytes")
    `C2U_ASSERT(a_done_single, aclk, aresetn, m_tvalid && kind_reg != c2u_pkg::KIND_DATA |-> left_reg == 2'd1, "string end not alone")

endmodule

`default_nettype wire

### rtl/cp932_to_utf8_stream_decoder_top.sv
// CP932 to UTF-8 stream decoder.
// Input channel s_*: tuser selects the item: load table entry, CP932 byte
// or finish string. Load items fill the 60x188 pair table (one RAM write);
// they must come before the bytes that use them.
// Output channel m_*: tuser gives the kind (UTF-8 byte, done ok, done
// error); tlast marks the last result of one input item.
// cfg_wr_en/cfg_wr_data set the output capacity; write only while idle.
// From input accept to first result, an item passes the table-read stage
// register (with the table RAM read), then the output serialiser register.
// Throughput: one input item per cycle while each item yields at most one
// result and m_tready is high; an item giving two or three UTF-8 bytes
// holds the input while the single output register serialises them.
// Reset clears decode state and sets capacity to 65535; the table is not
// cleared and must be loaded before use.
// When m_tready is low the output register holds; one more item waits in
// the table-read stage, after which s_tready drops.
`default_nettype none

module cp932_to_utf8_stream_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // action
    input  wire logic [39:0] s_tdata,   // in_byte, entry_index, entry_code, pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tlast,   // last_of_run
    output logic [1:0]       m_tuser,   // out_kind
    output logic [23:0]      m_tdata    // out_byte, out_length
);

    logic                       mem_we, mem_re;
    logic [c2u_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [c2u_pkg::CODE_W-1:0] mem_wdata, mem_rdata;
    logic                       st_valid, advance, grp_load, can_take;
    c2u_pkg::stage_t            st;
    c2u_pkg::group_t            grp;

    c2u_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .action      (s_tuser),
        .in_byte     (s_tdata[7:0]),
        .entry_index (s_tdata[21:8]),
        .entry_code  (s_tdata[37:22]),
        .advance     (advance),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .st_valid    (st_valid),
        .st          (st)
    );

    c2u_table_ram u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    c2u_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .st_valid    (st_valid),
        .st          (st),
        .rdata       (mem_rdata),
        .can_take    (can_take),
        .advance     (advance),
        .grp_load    (grp_load),
        .grp         (grp)
    );

    c2u_out_ser u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .grp_load (grp_load),
        .grp      (grp),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int IDLE_PERCENT  = 6;
    localparam int LOW_LEAD_ROWS = 31;    // rows reached by leads 0x81-0x9f
    localparam int LOW_COLUMNS   = 63;    // columns reached by trails 0x40-0x7e
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  act;
        logic [7:0]  cp_byte;
        logic [13:0] entry_idx;
        logic [15:0] entry_code;
        bit          drain;
    } cp932_item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] length;
        logic        last;
    } utf8_out_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic [1:0]  s_tuser     = c2u_pkg::ACT_LOAD;
    logic [39:0] s_tdata     = '0;
    logic        m_tready    = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic [23:0] m_tdata;

    cp932_to_utf8_stream_decoder_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // stimulus side
    cp932_item_t pending_items[$];
    cp932_item_t drive_item;
    bit          gen_loaded [c2u_pkg::TABLE_DEPTH];
    int          loaded_list[$];
    bit          gen_drain_next = 1'b0;
    bit          calm           = 1'b0;
    int          hold_requests  = 0;

    // decoder copy
    logic [15:0] pair_codes [c2u_pkg::TABLE_DEPTH];
    logic [5:0]  dec_row  = '0;
    bit          dec_lead = 1'b0;
    bit          dec_err  = 1'b0;
    int unsigned dec_used = 0;
    int unsigned dec_cap  = 65535;
    utf8_out_t   utf8_expected[$];
    int          awaiting_q = 0;

    int fail_count  = 0;
    int cycle_count = 0;
    int n_loads     = 0;
    int n_bytes     = 0;
    int n_finishes  = 0;
    int n_other     = 0;
    int n_utf8      = 0;
    int n_ok        = 0;
    int n_err       = 0;

    task automatic expect_result(input logic [1:0] kind, input logic [7:0] data,
                                 input logic [15:0] length, input logic last);
        utf8_out_t r;
        begin
            r.kind   = kind;
            r.data   = data;
            r.length = length;
            r.last   = last;
            utf8_expected.push_back(r);
        end
    endtask

    task automatic encode_utf8(input logic [15:0] ucs);
        int unsigned n;
        begin
            n = (ucs < 16'h0080) ? 1 : (ucs < 16'h0800) ? 2 : 3;
            // room needed for the terminator as well
            if (dec_used + n >= dec_cap) begin
                dec_err = 1'b1;
            end else begin
                if (n == 1) begin
                    expect_result(c2u_pkg::KIND_DATA, ucs[7:0], 16'h0, 1'b1);
                end else if (n == 2) begin
                    expect_result(c2u_pkg::KIND_DATA, {3'b110, ucs[10:6]}, 16'h0, 1'b0);
                    expect_result(c2u_pkg::KIND_DATA, {2'b10, ucs[5:0]}, 16'h0, 1'b1);
                end else begin
                    expect_result(c2u_pkg::KIND_DATA, {4'b1110, ucs[15:12]}, 16'h0, 1'b0);
                    expect_result(c2u_pkg::KIND_DATA, {2'b10, ucs[11:6]}, 16'h0, 1'b0);
                    expect_result(c2u_pkg::KIND_DATA, {2'b10, ucs[5:0]}, 16'h0, 1'b1);
                end
                dec_used = (dec_used + n) & 32'hffff;
            end
        end
    endtask

    task automatic decode_item(input logic [1:0] act, input logic [7:0] b,
                               input logic [13:0] entry_idx, input logic [15:0] entry_code);
        int          col;
        logic [15:0] ucs;
        begin
            case (act)
                c2u_pkg::ACT_LOAD: begin
                    if (entry_idx < c2u_pkg::TABLE_DEPTH)
                        pair_codes[entry_idx] = entry_code;
                end
                c2u_pkg::ACT_BYTE: begin
                    if (dec_err) begin
                        // swallowed until the string is finished
                    end else if (dec_lead) begin
                        dec_lead = 1'b0;
                        if (b >= 8'h40 && b <= 8'h7e)
                            col = int'(b - 8'h40);
                        else if (b >= 8'h80 && b <= 8'hfc)
                            col = LOW_COLUMNS + int'(b - 8'h80);
                        else
                            col = -1;
                        if (col < 0) begin
                            dec_err = 1'b1;
                        end else begin
                            ucs = pair_codes[dec_row * c2u_pkg::TRAIL_COLUMNS + col];
                            if (ucs == 16'h0)
                                dec_err = 1'b1;
                            else
                                encode_utf8(ucs);
                        end
                    end else if (b <= 8'h80) begin
                        encode_utf8({8'h00, b});
                    end else if (b >= 8'ha1 && b <= 8'hdf) begin
                        encode_utf8(16'hff61 + {8'h00, b - 8'ha1});
                    end else if (b == 8'ha0) begin
                        encode_utf8(16'hf8f0);
                    end else if (b >= 8'hfd) begin
                        encode_utf8(16'hf8f1 + {8'h00, b - 8'hfd});
                    end else begin
                        dec_row  = (b <= 8'h9f) ? 6'(b - 8'h81)
                                 : 6'(LOW_LEAD_ROWS + int'(b - 8'he0));
                        dec_lead = 1'b1;
                    end
                end
                c2u_pkg::ACT_FINISH: begin
                    if (dec_err || dec_lead || dec_used >= dec_cap)
                        expect_result(c2u_pkg::KIND_ERR, 8'h00, 16'h0, 1'b1);
                    else
                        expect_result(c2u_pkg::KIND_OK, 8'h00, dec_used[15:0], 1'b1);
                    dec_row  = '0;
                    dec_lead = 1'b0;
                    dec_used = 0;
                    dec_err  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_result();
        utf8_out_t want;
        begin
            if (m_tuser == c2u_pkg::KIND_DATA)
                n_utf8++;
            else if (m_tuser == c2u_pkg::KIND_OK)
                n_ok++;
            else
                n_err++;
            if (utf8_expected.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected item: kind %0d byte %02h length %0d last %0b",
                         $time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
            end else begin
                want = utf8_expected.pop_front();
                if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
                    m_tdata[23:8] !== want.length || m_tlast !== want.last) begin
                    fail_count++;
                    $display("%0t: mismatch: expected kind %0d byte %02h length %0d last %0b",
                             $time, want.kind, want.data, want.length, want.last);
                    $display("%0t:           got kind %0d byte %02h length %0d last %0b",
                             $time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
                end
            end
        end
    endtask

    // monitor: checks results, then predicts from the items accepted this edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            dec_row  = '0;
            dec_lead = 1'b0;
            dec_used = 0;
            dec_err  = 1'b0;
            dec_cap  = 65535;
            awaiting_q <= 0;
        end else begin
            if (cfg_wr_en)
                dec_cap = 32'(cfg_wr_data);
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    c2u_pkg::ACT_LOAD:   n_loads++;
                    c2u_pkg::ACT_BYTE:   n_bytes++;
                    c2u_pkg::ACT_FINISH: n_finishes++;
                    default:             n_other++;
                endcase
                decode_item(s_tuser, s_tdata[7:0], s_tdata[21:8], s_tdata[37:22]);
            end
            awaiting_q <= utf8_expected.size();
        end
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            // a drain item waits until every result so far has come out
            if (pending_items.size() != 0 &&
                !(pending_items[0].drain && (s_tvalid || awaiting_q != 0)) &&
                (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                drive_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drive_item.act;
                s_tdata  <= {2'b00, drive_item.entry_code, drive_item.entry_idx,
                             drive_item.cp_byte};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver with an occasional long hold-off
    int hold_left   = 0;
    int holds_taken = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_taken != hold_requests) begin
            holds_taken <= holds_taken + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= calm || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d items awaited",
                     $time, cycle_count, utf8_expected.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] any_single();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 45)
                any_single = 8'($urandom_range(8'h80));
            else if (r < 85)
                any_single = 8'($urandom_range(8'hdf, 8'ha1));
            else if (r < 92)
                any_single = 8'ha0;
            else
                any_single = 8'($urandom_range(8'hff, 8'hfd));
        end
    endfunction

    function automatic logic [7:0] any_lead();
        if ($urandom_range(1) == 0)
            any_lead = 8'($urandom_range(8'h9f, 8'h81));
        else
            any_lead = 8'($urandom_range(8'hfc, 8'he0));
    endfunction

    function automatic logic [7:0] any_bad_trail();
        int r;
        begin
            r = $urandom_range(2);
            if (r == 0)
                any_bad_trail = 8'($urandom_range(8'h3f));
            else if (r == 1)
                any_bad_trail = 8'h7f;
            else
                any_bad_trail = 8'($urandom_range(8'hff, 8'hfd));
        end
    endfunction

    function automatic logic [15:0] any_code();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 10)
                any_code = 16'h0;
            else if (r < 35)
                any_code = 16'($urandom_range(16'h007f, 16'h0001));
            else if (r < 60)
                any_code = 16'($urandom_range(16'h07ff, 16'h0080));
            else
                any_code = 16'($urandom_range(16'hffff, 16'h0800));
        end
    endfunction

    task automatic queue_item(input logic [1:0] act, input logic [7:0] b,
                              input logic [13:0] entry_idx, input logic [15:0] entry_code);
        cp932_item_t it;
        begin
            it.act        = act;
            it.cp_byte    = b;
            it.entry_idx  = entry_idx;
            it.entry_code = entry_code;
            it.drain      = gen_drain_next;
            gen_drain_next = 1'b0;
            pending_items.push_back(it);
        end
    endtask

    // fields an action does not use carry random values
    task automatic queue_byte(input logic [7:0] b);
        queue_item(c2u_pkg::ACT_BYTE, b, 14'($urandom_range(16383)),
                   16'($urandom_range(16'hffff)));
    endtask

    task automatic queue_finish();
        queue_item(c2u_pkg::ACT_FINISH, 8'($urandom_range(255)), 14'($urandom_range(16383)),
                   16'($urandom_range(16'hffff)));
    endtask

    task automatic queue_load(input int entry_idx, input logic [15:0] entry_code);
        begin
            queue_item(c2u_pkg::ACT_LOAD, 8'($urandom_range(255)), 14'(entry_idx),
                       entry_code);
            if (entry_idx < c2u_pkg::TABLE_DEPTH && !gen_loaded[entry_idx]) begin
                gen_loaded[entry_idx] = 1'b1;
                loaded_list.push_back(entry_idx);
            end
        end
    endtask

    task automatic queue_pair(input int entry_idx);
        int row;
        int col;
        begin
            row = entry_idx / c2u_pkg::TRAIL_COLUMNS;
            col = entry_idx % c2u_pkg::TRAIL_COLUMNS;
            queue_byte(row < LOW_LEAD_ROWS ? 8'(8'h81 + row)
                                           : 8'(8'he0 + (row - LOW_LEAD_ROWS)));
            queue_byte(col < LOW_COLUMNS ? 8'(8'h40 + col)
                                         : 8'(8'h80 + (col - LOW_COLUMNS)));
        end
    endtask

    // a lead byte is only ever followed by a trail into a loaded entry,
    // a bad trail, or the finish item
    task automatic queue_random_string(input int chars, input bit leave_open);
        int k;
        int r;
        begin
            for (k = 0; k < chars; k++) begin
                r = $urandom_range(99);
                if (r < 50) begin
                    queue_pair(loaded_list[$urandom_range(loaded_list.size() - 1)]);
                end else if (r < 80) begin
                    queue_byte(any_single());
                end else if (r < 85) begin
                    queue_byte(any_lead());
                    queue_byte(any_bad_trail());
                end else if (r < 89) begin
                    queue_load($urandom_range(c2u_pkg::TABLE_DEPTH - 1), any_code());
                end else if (r < 92) begin
                    queue_item(ACT_UNUSED, 8'($urandom_range(255)),
                               14'($urandom_range(16383)), 16'($urandom_range(16'hffff)));
                end else if (r < 94) begin
                    queue_load($urandom_range(16383, c2u_pkg::TABLE_DEPTH), any_code());
                end else begin
                    queue_byte(any_single());
                end
            end
            if (!leave_open) begin
                if ($urandom_range(99) < 10)
                    queue_byte(any_lead());
                queue_finish();
            end
        end
    endtask

    task automatic wait_idle();
        begin
            do
                @(negedge aclk);
            while (pending_items.size() != 0 || s_tvalid || awaiting_q != 0);
            // loads and swallowed bytes may still be in the pipe
            repeat (SETTLE_CYCLES) @(negedge aclk);
        end
    endtask

    task automatic set_capacity(input logic [15:0] bytes);
        begin
            wait_idle();
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= bytes;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            @(negedge aclk);
        end
    endtask

    initial begin
        int k;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: boundaries of each UTF-8 length, row and column ends
        queue_load(0, 16'h3042);
        queue_load(c2u_pkg::TABLE_DEPTH - 1, 16'hffff);
        queue_load(62, 16'h07ff);
        queue_load(63, 16'h0041);
        queue_load(LOW_LEAD_ROWS * c2u_pkg::TRAIL_COLUMNS, 16'h0800);
        queue_load(5 * c2u_pkg::TRAIL_COLUMNS + 7, 16'h0000);
        queue_byte(8'h00);
        queue_byte(8'h80);
        queue_byte(8'ha0);
        queue_byte(8'hdf);
        queue_byte(8'hff);
        queue_pair(0);
        queue_pair(c2u_pkg::TABLE_DEPTH - 1);
        queue_pair(62);
        queue_pair(63);
        queue_pair(LOW_LEAD_ROWS * c2u_pkg::TRAIL_COLUMNS);
        queue_finish();
        // bad trail, then a byte that must be swallowed
        queue_byte(8'h81);
        queue_byte(8'h7f);
        queue_byte(8'h41);
        queue_finish();
        queue_pair(5 * c2u_pkg::TRAIL_COLUMNS + 7);
        queue_finish();
        // lead byte left dangling
        queue_byte(8'h85);
        queue_finish();
        queue_finish();

        set_capacity(16'd0);
        queue_byte(8'h41);
        queue_finish();
        queue_finish();

        set_capacity(16'd1);
        queue_byte(8'h41);
        queue_finish();
        queue_finish();

        set_capacity(16'($urandom_range(12, 4)));
        for (k = 0; k < 2; k++)
            queue_random_string($urandom_range(5, 2), 1'b0);
        queue_random_string(3, 1'b1);

        // capacity lowered under a half-built string
        set_capacity(16'd2);
        queue_finish();
        queue_random_string(2, 1'b0);

        set_capacity(16'hffff);
        for (k = 0; k < 6; k++)
            queue_load($urandom_range(c2u_pkg::TABLE_DEPTH - 1), any_code());
        queue_item(ACT_UNUSED, 8'hff, 14'h3fff, 16'hffff);
        queue_load(c2u_pkg::TABLE_DEPTH, 16'hbeef);
        for (k = 0; k < 2; k++)
            queue_random_string($urandom_range(8, 1), 1'b0);
        do
            @(negedge aclk);
        while (pending_items.size() != 0);
        // receiver stalls while the sender keeps offering
        hold_requests = hold_requests + 1;
        for (k = 0; k < 2; k++)
            queue_random_string($urandom_range(8, 3), 1'b0);

        set_capacity(16'($urandom_range(40, 16)));
        calm = 1'b1;
        for (k = 0; k < 2; k++) begin
            gen_drain_next = 1'b1;
            queue_random_string($urandom_range(5, 3), 1'b0);
        end
        wait_idle();
        calm = 1'b0;

        wait_idle();
        if (utf8_expected.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected items never came", $time, utf8_expected.size());
        end
        $display("run: %0d loads, %0d CP932 bytes, %0d finishes, %0d ignored-action items",
                 n_loads, n_bytes, n_finishes, n_other);
        $display("run: %0d UTF-8 bytes out, %0d strings ok, %0d strings in error, %0d failures",
                 n_utf8, n_ok, n_err, fail_count);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
